### design/idr_pkg.sv
// Shared types and constants for the inversion disorder ratio core.
// No dependencies; used by the front end, queue, back end and top of the block.
package idr_pkg;

    localparam int VALUE_W     = 32;
    localparam int INV_W       = 17;
    localparam int RATIO_W     = 17;
    localparam int ITEM_CNT_W  = 10;
    localparam int FRAC_W      = 16;
    localparam int DVD_W       = INV_W + FRAC_W;
    localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [INV_W-1:0]   INV_MAX   = '1;
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);
    // flipping the sign bit makes an unsigned compare order signed values
    localparam logic [VALUE_W-1:0] SIGN_FLIP = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic [RATIO_W-1:0]    disorder_q16;
        logic [INV_W-1:0]      inversions;
        logic [ITEM_CNT_W-1:0] item_count;
        logic                  sorted;
        logic                  overflow;
    } out_item_t;

    // command passed from the front end to the back end
    typedef struct packed {
        logic [VALUE_W-1:0] key;
        logic               last;
        logic               drop;
    } cmd_t;

endpackage

### design/idr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module idr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/idr_front.sv
// Front end: takes input items, tracks store fill and marks items to drop.
// Depends on idr_pkg.
module idr_front #(
    parameter int MAX_ITEMS = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  idr_pkg::in_item_t in_data,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output idr_pkg::cmd_t    cmd
);
    import idr_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             full;
    logic             accept;

    assign full      = (fill_reg == CNT_W'(MAX_ITEMS));
    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid & cmd_ready;

    always_comb
    begin
        cmd.key  = $unsigned(in_data.value) ^ SIGN_FLIP;
        cmd.last = in_data.last;
        cmd.drop = full;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            if (in_data.last)
            begin
                fill_next = '0;
            end
            else if (!full)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

### design/idr_queue.sv
// Short command FIFO between front end and back end.
// Depends on idr_pkg.
module idr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  idr_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output idr_pkg::cmd_t pop_data
);
    import idr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/idr_back.sv
// Back end: scans stored values, counts inversions, stores the value and,
// at the end of a sequence, forms the pair count and the serial ratio divide.
// Depends on idr_pkg and idr_ram.
module idr_back #(
    parameter int MAX_ITEMS = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  idr_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output idr_pkg::out_item_t out_data
);
    import idr_pkg::*;

    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W  = $clog2(MAX_ITEMS);
    localparam int PAIRS_W = 2 * CNT_W - 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_PAIRS = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic [VALUE_W-1:0]   key_reg, key_next;
    logic                 last_reg, last_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [INV_W-1:0]     inv_reg, inv_next;
    logic                 drop_reg, drop_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [PAIRS_W-1:0]   pairs_reg, pairs_next;
    logic [PAIRS_W-1:0]   rem_reg, rem_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [VALUE_W-1:0]   ram_rd_data;
    logic [2*CNT_W-1:0]   prod;
    logic [PAIRS_W:0]     trial;
    logic [PAIRS_W:0]     diff;
    logic                 ge;
    logic [RATIO_W-1:0]   ratio;

    assign ram_rd_en = (state_reg == ST_SCAN) && (rd_idx_reg < cnt_reg);
    assign ram_wr_en = (state_reg == ST_SCAN) && (rd_idx_reg == cnt_reg);

    idr_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(MAX_ITEMS)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(cnt_reg[ADDR_W-1:0]),
        .wr_data(key_reg),
        .rd_en  (ram_rd_en),
        .rd_addr(rd_idx_reg[ADDR_W-1:0]),
        .rd_data(ram_rd_data)
    );

    assign prod  = {{CNT_W{1'b0}}, cnt_reg} * {{CNT_W{1'b0}}, cnt_reg - CNT_W'(1)};
    // restoring divide, one quotient bit per cycle
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, pairs_reg};
    assign ge    = (trial >= {1'b0, pairs_reg});
    assign ratio = (dvd_reg > DVD_W'(RATIO_ONE)) ? RATIO_ONE : dvd_reg[RATIO_W-1:0];

    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        inv_next       = inv_reg;
        drop_next      = drop_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        pairs_next     = pairs_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // compare of the word read in the previous cycle
        if (cmp_vld_reg && (ram_rd_data > key_reg) && (inv_reg != INV_MAX))
        begin
            inv_next = inv_reg + INV_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    key_next  = cmd.key;
                    last_next = cmd.last;
                    if (cmd.drop)
                    begin
                        drop_next = 1'b1;
                        if (cmd.last)
                        begin
                            state_next = ST_PAIRS;
                        end
                    end
                    else
                    begin
                        rd_idx_next = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg < cnt_reg)
                begin
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    state_next   = last_reg ? ST_PAIRS : ST_IDLE;
                end
            end
            ST_PAIRS:
            begin
                pairs_next = prod[2*CNT_W-1:1];
                rem_next   = '0;
                step_next  = '0;
                if (cnt_reg < CNT_W'(2))
                begin
                    dvd_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    dvd_next   = {inv_reg, {FRAC_W{1'b0}}};
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? diff[PAIRS_W-1:0] : trial[PAIRS_W-1:0];
                dvd_next  = {dvd_reg[DVD_W-2:0], ge};
                step_next = step_reg + DIV_CNT_W'(1);
                if (step_reg == DIV_CNT_W'(DVD_W - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.disorder_q16 = ratio;
                    out_next.inversions   = inv_reg;
                    out_next.item_count   = ITEM_CNT_W'(cnt_reg);
                    out_next.sorted       = (inv_reg == '0);
                    out_next.overflow     = drop_reg;
                    out_valid_next        = 1'b1;
                    cnt_next              = '0;
                    inv_next              = '0;
                    drop_next             = 1'b0;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            inv_reg       <= '0;
            drop_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            step_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            inv_reg       <= inv_next;
            drop_reg      <= drop_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        pairs_reg <= pairs_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        out_reg   <= out_next;
    end

endmodule

### design/inversion_disorder_ratio_core.sv
// A stored item occupies the back end while it scans the n values already stored in the
// sequence (at most MAX_ITEMS - 1), one store read per cycle, and then writes its own value.
// The item that ends a sequence then passes through the pair product, 33 divide steps
// (skipped for fewer than two items) and the output load; no new item is taken until idle.
// Reset clears all counters, empties the queue and clears out_valid; the value store is not
// cleared and is only read at entries written in the current sequence.
module inversion_disorder_ratio_core #(
    parameter int MAX_ITEMS = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  idr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output idr_pkg::out_item_t out_data
);
    import idr_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    idr_front #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cmd_valid(push_valid),
        .cmd_ready(push_ready),
        .cmd      (push_cmd)
    );

    idr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_cmd),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_cmd)
    );

    idr_back #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(pop_valid),
        .cmd_ready(pop_ready),
        .cmd      (pop_cmd),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

`ifndef SYNTHESIS
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.disorder_q16 <= RATIO_ONE))
        else $error("disorder ratio above one");

    a_sorted_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.sorted) |-> (out_data.disorder_q16 == '0))
        else $error("sorted sequence with nonzero ratio");

    a_full_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.disorder_q16 == RATIO_ONE)) |-> (out_data.inversions != '0))
        else $error("full disorder ratio without inversions");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for inversion_disorder_ratio_core: value sequences go in, per-sequence
// summaries (inversions, count, sorted, overflow, Q1.16 disorder) are predicted and compared.
// Depends on idr_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import idr_pkg::*;

    localparam int CAPACITY      = 512;
    localparam int WATCHDOG_MAX  = 4096;
    localparam int SETTLE_CYCLES = 600;
    localparam int ITEM_TARGET   = 1170;
    localparam int CALM_TAIL     = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    inversion_disorder_ratio_core #(.MAX_ITEMS(CAPACITY)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // stimulus waiting to be driven; a set hold flag makes the sender wait for all summaries
    in_item_t  value_q[$];
    bit        hold_q[$];
    int        items_queued = 0;

    // predictor state for the sequence in progress
    logic signed [VALUE_W-1:0] seq_vals [CAPACITY];
    int        seq_len = 0;
    int        inv_sum = 0;
    bit        seq_dropped = 1'b0;
    out_item_t summary_q[$];

    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        tick = 0;
    bit        in_taken = 1'b0;
    int        send_gap = 0;
    int        ready_gap = 0;

    wire idle_on = (tick % 3000) < 2000;
    wire calm    = value_q.size() < CALM_TAIL;

    task automatic absorb_value(input in_item_t it);
        int        hits;
        longint    pairs;
        longint    ratio;
        out_item_t res;
        if (seq_len < CAPACITY)
        begin
            hits = 0;
            for (int i = 0; i < seq_len; i++)
                if (seq_vals[i] > it.value)
                    hits++;
            if (inv_sum + hits > int'(INV_MAX))
                inv_sum = int'(INV_MAX);
            else
                inv_sum += hits;
            seq_vals[seq_len] = it.value;
            seq_len++;
        end
        else
            seq_dropped = 1'b1;
        if (it.last)
        begin
            ratio = 0;
            if (seq_len >= 2)
            begin
                pairs = longint'(seq_len) * longint'(seq_len - 1) / 2;
                ratio = (longint'(inv_sum) << FRAC_W) / pairs;
                if (ratio > 65536)
                    ratio = 65536;
            end
            res.disorder_q16 = RATIO_W'(ratio);
            res.inversions   = INV_W'(inv_sum);
            res.item_count   = ITEM_CNT_W'(seq_len);
            res.sorted       = (inv_sum == 0);
            res.overflow     = seq_dropped;
            summary_q.push_back(res);
            seq_len     = 0;
            inv_sum     = 0;
            seq_dropped = 1'b0;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    // transfer bookkeeping, prediction and result checking
    always @(posedge clk)
    begin
        out_item_t want;
        tick <= tick + 1;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                absorb_value(in_data);
            if (out_valid && out_ready)
            begin
                if (summary_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected summary: inversions %0d, count %0d",
                                 out_data.inversions, out_data.item_count);
                end
                else
                begin
                    want = summary_q.pop_front();
                    check_field("disorder_q16", 32'(want.disorder_q16), 32'(out_data.disorder_q16));
                    check_field("inversions", 32'(want.inversions), 32'(out_data.inversions));
                    check_field("item_count", 32'(want.item_count), 32'(out_data.item_count));
                    check_field("sorted", 32'(want.sorted), 32'(out_data.sorted));
                    check_field("overflow", 32'(want.overflow), 32'(out_data.overflow));
                end
            end
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (value_q.size() > 0 && !(hold_q[0] && summary_q.size() != 0))
            begin
                if (!calm && idle_on && $urandom_range(0, 5) == 0)
                begin
                    send_gap <= $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_data  <= value_q.pop_front();
                    void'(hold_q.pop_front());
                    in_valid <= 1'b1;
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result-side backpressure
    always @(negedge clk)
    begin
        if (ready_gap > 0)
        begin
            ready_gap <= ready_gap - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && idle_on && $urandom_range(0, 3) == 0)
        begin
            ready_gap <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic add_value(input logic signed [VALUE_W-1:0] v, input bit last,
                             input bit hold);
        in_item_t it;
        it.value = v;
        it.last  = last;
        value_q.push_back(it);
        hold_q.push_back(hold);
        items_queued++;
    endtask

    task automatic add_random_sequence(input int len, input bit hold);
        int                        style;
        int                        base;
        logic signed [VALUE_W-1:0] v;
        style = $urandom_range(0, 4);
        base  = int'($urandom_range(0, 2000)) - 1000;
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0: v = $urandom;
                1: v = int'($urandom_range(0, 16)) - 8;        // many equal values
                2: v = base + i * int'($urandom_range(0, 3));  // base plus index times a random 0 to 3, mostly rising
                3:
                begin
                    case ($urandom_range(0, 4))
                        0: v = 32'sh8000_0000;
                        1: v = 32'sh7FFF_FFFF;
                        2: v = -32'sd1;
                        3: v = 32'sd0;
                        default: v = 32'sd1;
                    endcase
                end
                default: v = base + i * 4 + int'($urandom_range(0, 6));  // nearly sorted
            endcase
            add_value(v, i == len - 1, hold && i == 0);
        end
    endtask

    // fills the store with strictly falling values, then two dropped items, last on the second
    task automatic add_full_descending();
        int v;
        v = 32'sh7FFF_FFFF - int'($urandom_range(0, 100));
        for (int i = 0; i < CAPACITY; i++)
        begin
            add_value(v, 1'b0, i == 0);
            v -= int'($urandom_range(1, 1000000));
        end
        add_value($urandom, 1'b0, 1'b0);
        add_value($urandom, 1'b1, 1'b0);
    endtask

    initial
    begin
        // lone item: no pairs
        add_value(32'sh8000_0000, 1'b1, 1'b0);
        // extremes in both orders
        add_value(32'sh7FFF_FFFF, 1'b0, 1'b0);
        add_value(32'sh8000_0000, 1'b1, 1'b0);
        add_value(32'sh8000_0000, 1'b0, 1'b0);
        add_value(32'sh7FFF_FFFF, 1'b1, 1'b0);
        // equal values never count
        add_value(32'sd5, 1'b0, 1'b0);
        add_value(32'sd5, 1'b0, 1'b0);
        add_value(32'sd5, 1'b1, 1'b0);
        // sign boundary
        add_value(-32'sd1, 1'b0, 1'b0);
        add_value(32'sd0, 1'b1, 1'b0);
        add_value(32'sd0, 1'b0, 1'b0);
        add_value(-32'sd1, 1'b1, 1'b0);
        add_value(32'sd3, 1'b0, 1'b0);
        add_value(32'sd1, 1'b0, 1'b0);
        add_value(32'sd2, 1'b0, 1'b0);
        add_value(-32'sd7, 1'b0, 1'b0);
        add_value(32'sh7FFF_FFFF, 1'b1, 1'b0);

        add_full_descending();
        add_random_sequence($urandom_range(1, 12), 1'b1);
        while (items_queued < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                add_random_sequence($urandom_range(13, 60), $urandom_range(0, 19) == 0);
            else
                add_random_sequence($urandom_range(1, 12), $urandom_range(0, 19) == 0);
        end

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        while (value_q.size() != 0 || in_valid)
            @(posedge clk);
        while (summary_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && summary_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
